/* rtl/core/i2cbb_pkg.sv */
// Package for the I2C bit engine: word types, phase codes, command codes
// and the engine state record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package i2cbb_pkg;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_ST1  = 4'd1;
	localparam logic [3:0] PH_ST2  = 4'd2;
	localparam logic [3:0] PH_ST3  = 4'd3;
	localparam logic [3:0] PH_SP1  = 4'd4;
	localparam logic [3:0] PH_SP2  = 4'd5;
	localparam logic [3:0] PH_SP3  = 4'd6;
	localparam logic [3:0] PH_WH   = 4'd7;
	localparam logic [3:0] PH_WL   = 4'd8;
	localparam logic [3:0] PH_WA   = 4'd9;
	localparam logic [3:0] PH_WAL  = 4'd10;
	localparam logic [3:0] PH_RS   = 4'd11;
	localparam logic [3:0] PH_RH   = 4'd12;
	localparam logic [3:0] PH_RL   = 4'd13;
	localparam logic [3:0] PH_RA   = 4'd14;
	localparam logic [3:0] PH_RAL  = 4'd15;

	localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;
	localparam logic [15:0] SLOT_TICKS_RESET = 16'd10;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] tx_data;
		logic       nack_after;
		logic       sda_in;
		logic       scl_in;
	} in_word_t;

	typedef struct packed {
		logic       scl_level;
		logic       scl_drive;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       ack_error;
		logic [7:0] rx_data;
	} out_word_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [3:0]  bit_count;
		logic [7:0]  shift_reg;
		logic [15:0] slot_count;
		logic        ack_flag;
		logic        nack_bit;
		logic [7:0]  rx_hold;
		logic        scl_lv;
		logic        scl_dr;
		logic        sda_lv;
		logic        sda_dr;
	} eng_state_t;

	localparam eng_state_t ENG_STATE_RESET = '{
		phase: PH_IDLE, bit_count: 4'd0, shift_reg: 8'd0, slot_count: 16'd0,
		ack_flag: 1'b0, nack_bit: 1'b0, rx_hold: 8'd0,
		scl_lv: 1'b1, scl_dr: 1'b0, sda_lv: 1'b1, sda_dr: 1'b0
	};

endpackage
`default_nettype wire

/* rtl/core/i2cbb_engine.sv */
// Next-state logic of the I2C bit engine for one tick.
// Depends on i2cbb_pkg for the state record, phase and command codes.
`timescale 1ns / 1ps
`default_nettype none
module i2cbb_engine (
	input  wire i2cbb_pkg::eng_state_t cur,
	input  wire i2cbb_pkg::in_word_t   item,
	input  wire logic [15:0]           slot_ticks,
	output i2cbb_pkg::eng_state_t      nxt,
	output logic                       done
);

	logic [16:0] slot_inc;
	logic [15:0] slot_lim;
	logic        slot_over;
	logic [15:0] slot_after;
	logic [7:0]  wr_shift;
	logic [3:0]  bit_inc;

	// A slot length of zero behaves as one tick.
	assign slot_lim   = (slot_ticks == 16'd0) ? 16'd1 : slot_ticks;
	assign slot_inc   = {1'b0, cur.slot_count} + 17'd1;
	assign slot_over  = slot_inc >= {1'b0, slot_lim};
	assign slot_after = slot_over ? 16'd0 : slot_inc[15:0];
	assign wr_shift   = {cur.shift_reg[6:0], 1'b0};
	assign bit_inc    = cur.bit_count + 4'd1;

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		unique case (cur.phase) inside
			i2cbb_pkg::PH_IDLE: begin
				nxt.slot_count = 16'd0;
				case (item.command)
					i2cbb_pkg::CMD_START: begin
						nxt.sda_dr = 1'b1;
						nxt.sda_lv = 1'b1;
						nxt.scl_dr = 1'b1;
						nxt.scl_lv = 1'b1;
						nxt.phase  = i2cbb_pkg::PH_ST1;
					end
					i2cbb_pkg::CMD_STOP: begin
						nxt.sda_dr = 1'b1;
						nxt.sda_lv = 1'b0;
						nxt.phase  = i2cbb_pkg::PH_SP1;
					end
					i2cbb_pkg::CMD_WRITE: begin
						nxt.shift_reg = item.tx_data;
						nxt.bit_count = 4'd0;
						nxt.sda_dr    = 1'b1;
						nxt.sda_lv    = item.tx_data[7];
						nxt.scl_dr    = 1'b1;
						nxt.scl_lv    = 1'b1;
						nxt.phase     = i2cbb_pkg::PH_WH;
					end
					i2cbb_pkg::CMD_READ: begin
						nxt.nack_bit  = item.nack_after;
						nxt.shift_reg = 8'd0;
						nxt.bit_count = 4'd0;
						nxt.sda_dr    = 1'b0;
						nxt.scl_dr    = 1'b0;
						nxt.scl_lv    = 1'b1;
						nxt.phase     = i2cbb_pkg::PH_RS;
					end
					default: begin
						nxt.phase = i2cbb_pkg::PH_IDLE;
					end
				endcase
			end
			i2cbb_pkg::PH_ST1: begin
				nxt.slot_count = slot_after;
				if (slot_over) begin
					nxt.sda_lv = 1'b0;
					nxt.phase  = i2cbb_pkg::PH_ST2;
				end
			end
			i2cbb_pkg::PH_ST2: begin
				nxt.slot_count = slot_after;
				if (slot_over) begin
					nxt.scl_lv = 1'b0;
					nxt.phase  = i2cbb_pkg::PH_ST3;
				end
			end
			i2cbb_pkg::PH_SP1: begin
				nxt.slot_count = slot_after;
				if (slot_over) begin
					nxt.scl_dr = 1'b1;
					nxt.scl_lv = 1'b1;
					nxt.phase  = i2cbb_pkg::PH_SP2;
				end
			end
			i2cbb_pkg::PH_SP2: begin
				nxt.slot_count = slot_after;
				if (slot_over) begin
					nxt.sda_lv = 1'b1;
					nxt.phase  = i2cbb_pkg::PH_SP3;
				end
			end
			i2cbb_pkg::PH_WH: begin
				nxt.slot_count = slot_after;
				if (slot_over) begin
					nxt.scl_lv = 1'b0;
					nxt.phase  = i2cbb_pkg::PH_WL;
				end
			end
			i2cbb_pkg::PH_WL: begin
				nxt.slot_count = slot_after;
				if (slot_over) begin
					nxt.shift_reg = wr_shift;
					nxt.bit_count = bit_inc;
					if (bit_inc < i2cbb_pkg::BITS_PER_BYTE) begin
						nxt.sda_lv = wr_shift[7];
						nxt.phase  = i2cbb_pkg::PH_WH;
					end else begin
						// Release SDA so the target can acknowledge.
						nxt.sda_dr = 1'b0;
						nxt.phase  = i2cbb_pkg::PH_WA;
					end
					nxt.scl_lv = 1'b1;
				end
			end
			i2cbb_pkg::PH_WA: begin
				nxt.slot_count = slot_after;
				if (slot_over) begin
					nxt.ack_flag = item.sda_in;
					nxt.scl_lv   = 1'b0;
					nxt.phase    = i2cbb_pkg::PH_WAL;
				end
			end
			i2cbb_pkg::PH_RS: begin
				// Wait here while the target stretches the clock.
				if (item.scl_in) begin
					nxt.scl_dr     = 1'b1;
					nxt.scl_lv     = 1'b1;
					nxt.slot_count = 16'd0;
					nxt.phase      = i2cbb_pkg::PH_RH;
				end
			end
			i2cbb_pkg::PH_RH: begin
				nxt.slot_count = slot_after;
				if (slot_over) begin
					nxt.shift_reg = {cur.shift_reg[6:0], item.sda_in};
					nxt.scl_lv    = 1'b0;
					nxt.phase     = i2cbb_pkg::PH_RL;
				end
			end
			i2cbb_pkg::PH_RL: begin
				nxt.slot_count = slot_after;
				if (slot_over) begin
					nxt.bit_count = bit_inc;
					if (bit_inc < i2cbb_pkg::BITS_PER_BYTE) begin
						nxt.scl_dr = 1'b0;
						nxt.scl_lv = 1'b1;
						nxt.phase  = i2cbb_pkg::PH_RS;
					end else begin
						nxt.rx_hold = cur.shift_reg;
						nxt.sda_dr  = 1'b1;
						nxt.sda_lv  = cur.nack_bit;
						nxt.scl_lv  = 1'b1;
						nxt.phase   = i2cbb_pkg::PH_RA;
					end
				end
			end
			i2cbb_pkg::PH_RA: begin
				nxt.slot_count = slot_after;
				if (slot_over) begin
					nxt.scl_lv = 1'b0;
					nxt.phase  = i2cbb_pkg::PH_RAL;
				end
			end
			i2cbb_pkg::PH_ST3, i2cbb_pkg::PH_SP3, i2cbb_pkg::PH_WAL,
			i2cbb_pkg::PH_RAL: begin
				nxt.slot_count = slot_after;
				if (slot_over) begin
					nxt.phase = i2cbb_pkg::PH_IDLE;
					done      = 1'b1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/i2c_bitbang_master.sv */
// Top level of the I2C bit engine: input register, engine state, result register.
// Depends on i2cbb_pkg and i2cbb_engine.
`timescale 1ns / 1ps
`default_nettype none
// Each input word is one tick of the I2C bit engine and yields exactly one
// result word showing the line drives and status after that tick. A word is
// registered on entry, passed once through the engine's next-state logic and
// the result is registered on exit, so one word is taken every clock cycle
// unless out_ready holds the result register; the input register and the
// result register are the only stages, and state_q closes the engine loop.
// slot_ticks (reset 10) sets the ticks per delay slot and may be written
// only while no words are in flight; cfg_ready is always high.
module i2c_bitbang_master (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire i2cbb_pkg::in_word_t   in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output i2cbb_pkg::out_word_t       out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [15:0]           cfg_data
);

	logic                  valid_s1;
	i2cbb_pkg::in_word_t   item_s1;
	i2cbb_pkg::eng_state_t state_q;
	i2cbb_pkg::eng_state_t state_nxt;
	logic                  done_nxt;
	logic [15:0]           slot_ticks_q;
	logic                  out_valid_q;
	i2cbb_pkg::out_word_t  out_q;
	logic                  advance;

	// The held word advances whenever the result register is free or being emptied.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	i2cbb_engine u_engine (
		.cur        (state_q),
		.item       (item_s1),
		.slot_ticks (slot_ticks_q),
		.nxt        (state_nxt),
		.done       (done_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_ticks_q <= i2cbb_pkg::SLOT_TICKS_RESET;
		end else if (cfg_valid) begin
			slot_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= i2cbb_pkg::ENG_STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.scl_level <= state_nxt.scl_lv;
			out_q.scl_drive <= state_nxt.scl_dr;
			out_q.sda_level <= state_nxt.sda_lv;
			out_q.sda_drive <= state_nxt.sda_dr;
			out_q.busy_res  <= (state_nxt.phase != i2cbb_pkg::PH_IDLE);
			out_q.done_res  <= done_nxt;
			out_q.ack_error <= state_nxt.ack_flag;
			out_q.rx_data   <= state_nxt.rx_hold;
		end
	end

endmodule
`default_nettype wire

/* test/i2c_bitbang_master_tb.sv */
// Self-checking testbench for the I2C bit engine: a directed table, then random
// command sequences under several slot lengths, checked word by word against a predictor.
// Depends on i2cbb_pkg and the i2c_bitbang_master RTL.
`timescale 1ns / 1ps
module i2c_bitbang_master_tb;

	// Some two thousand words go in under the heaviest stalls;
	// the limit leaves ample room above that.
	localparam int          CYCLE_LIMIT  = 200_000;
	localparam int          DRAIN_CYCLES = 8;
	localparam logic [2:0]  CMD_TOP      = 3'd7;

	typedef struct {
		bit                   is_cfg;
		logic [15:0]          cfg_val;
		i2cbb_pkg::in_word_t  word;
		bit                   typed;
		i2cbb_pkg::out_word_t want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	i2cbb_pkg::in_word_t  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	i2cbb_pkg::out_word_t out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [15:0]          cfg_data  = '0;

	i2c_bitbang_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Predicted engine state and the slot length register.
	logic [15:0] slot_len;
	logic [3:0]  eng_phase;
	logic [3:0]  bit_idx;
	logic [7:0]  shifter;
	logic [7:0]  rx_byte;
	int unsigned slot_cnt;
	logic        ack_seen;
	logic        send_nack;
	logic        scl_lv, scl_dr, sda_lv, sda_dr;

	i2cbb_pkg::out_word_t expected_lines[$];

	int mismatches      = 0;
	int results_checked = 0;
	int items_sent      = 0;
	int stretch_ticks   = 0;
	int op_count[8];
	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("i2c_bitbang_master verification failed");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic note_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	always @(posedge clk) begin : result_check
		i2cbb_pkg::out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_lines.size() == 0) begin
				note_mismatch("result word with nothing expected");
			end else begin
				want = expected_lines.pop_front();
				check_field("scl_level", 8'(out_data.scl_level), 8'(want.scl_level));
				check_field("scl_drive", 8'(out_data.scl_drive), 8'(want.scl_drive));
				check_field("sda_level", 8'(out_data.sda_level), 8'(want.sda_level));
				check_field("sda_drive", 8'(out_data.sda_drive), 8'(want.sda_drive));
				check_field("busy_res",  8'(out_data.busy_res),  8'(want.busy_res));
				check_field("done_res",  8'(out_data.done_res),  8'(want.done_res));
				check_field("ack_error", 8'(out_data.ack_error), 8'(want.ack_error));
				check_field("rx_data",   out_data.rx_data,       want.rx_data);
				results_checked++;
			end
		end
	end

	// A slot of length zero behaves as a slot of one tick.
	function automatic bit slot_elapsed();
		int unsigned lim;
		lim = (slot_len == 16'd0) ? 1 : slot_len;
		slot_cnt++;
		if (slot_cnt >= lim) begin
			slot_cnt = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic i2cbb_pkg::out_word_t line_tick(i2cbb_pkg::in_word_t w);
		i2cbb_pkg::out_word_t o;
		logic done;
		done = 1'b0;
		case (eng_phase)
		i2cbb_pkg::PH_IDLE: begin
			slot_cnt = 0;
			case (w.command)
			i2cbb_pkg::CMD_START: begin
				sda_dr = 1'b1; sda_lv = 1'b1; scl_dr = 1'b1; scl_lv = 1'b1;
				eng_phase = i2cbb_pkg::PH_ST1;
			end
			i2cbb_pkg::CMD_STOP: begin
				sda_dr = 1'b1; sda_lv = 1'b0;
				eng_phase = i2cbb_pkg::PH_SP1;
			end
			i2cbb_pkg::CMD_WRITE: begin
				shifter = w.tx_data; bit_idx = '0;
				sda_dr = 1'b1; sda_lv = w.tx_data[7];
				scl_dr = 1'b1; scl_lv = 1'b1;
				eng_phase = i2cbb_pkg::PH_WH;
			end
			i2cbb_pkg::CMD_READ: begin
				send_nack = w.nack_after; shifter = '0; bit_idx = '0;
				sda_dr = 1'b0; scl_dr = 1'b0; scl_lv = 1'b1;
				eng_phase = i2cbb_pkg::PH_RS;
			end
			default: ;
			endcase
		end
		i2cbb_pkg::PH_ST1: if (slot_elapsed()) begin
			sda_lv = 1'b0; eng_phase = i2cbb_pkg::PH_ST2;
		end
		i2cbb_pkg::PH_ST2: if (slot_elapsed()) begin
			scl_lv = 1'b0; eng_phase = i2cbb_pkg::PH_ST3;
		end
		i2cbb_pkg::PH_SP1: if (slot_elapsed()) begin
			scl_dr = 1'b1; scl_lv = 1'b1; eng_phase = i2cbb_pkg::PH_SP2;
		end
		i2cbb_pkg::PH_SP2: if (slot_elapsed()) begin
			sda_lv = 1'b1; eng_phase = i2cbb_pkg::PH_SP3;
		end
		i2cbb_pkg::PH_WH: if (slot_elapsed()) begin
			scl_lv = 1'b0; eng_phase = i2cbb_pkg::PH_WL;
		end
		i2cbb_pkg::PH_WL: if (slot_elapsed()) begin
			shifter = shifter << 1;
			bit_idx++;
			if (bit_idx < i2cbb_pkg::BITS_PER_BYTE) begin
				sda_lv = shifter[7];
				eng_phase = i2cbb_pkg::PH_WH;
			end else begin
				sda_dr = 1'b0;
				eng_phase = i2cbb_pkg::PH_WA;
			end
			scl_lv = 1'b1;
		end
		i2cbb_pkg::PH_WA: if (slot_elapsed()) begin
			ack_seen = w.sda_in; scl_lv = 1'b0; eng_phase = i2cbb_pkg::PH_WAL;
		end
		// The slave may hold SCL low; the bit only starts once it is seen high.
		i2cbb_pkg::PH_RS: if (w.scl_in) begin
			scl_dr = 1'b1; scl_lv = 1'b1; slot_cnt = 0; eng_phase = i2cbb_pkg::PH_RH;
		end
		i2cbb_pkg::PH_RH: if (slot_elapsed()) begin
			shifter = {shifter[6:0], w.sda_in};
			scl_lv = 1'b0;
			eng_phase = i2cbb_pkg::PH_RL;
		end
		i2cbb_pkg::PH_RL: if (slot_elapsed()) begin
			bit_idx++;
			if (bit_idx < i2cbb_pkg::BITS_PER_BYTE) begin
				scl_dr = 1'b0; scl_lv = 1'b1;
				eng_phase = i2cbb_pkg::PH_RS;
			end else begin
				rx_byte = shifter;
				sda_dr = 1'b1; sda_lv = send_nack;
				scl_lv = 1'b1;
				eng_phase = i2cbb_pkg::PH_RA;
			end
		end
		i2cbb_pkg::PH_RA: if (slot_elapsed()) begin
			scl_lv = 1'b0; eng_phase = i2cbb_pkg::PH_RAL;
		end
		default: if (slot_elapsed()) begin
			eng_phase = i2cbb_pkg::PH_IDLE; done = 1'b1;
		end
		endcase
		o = '{scl_lv, scl_dr, sda_lv, sda_dr, eng_phase != i2cbb_pkg::PH_IDLE, done,
			ack_seen, rx_byte};
		return o;
	endfunction

	// Mostly real commands when idle and plain ticks when busy, with some noise.
	function automatic i2cbb_pkg::in_word_t pick_word();
		i2cbb_pkg::in_word_t w;
		int roll;
		w.tx_data    = 8'($urandom_range(255));
		w.nack_after = 1'($urandom_range(1));
		w.sda_in     = 1'($urandom_range(1));
		w.scl_in     = (eng_phase == i2cbb_pkg::PH_RS) ? ($urandom_range(9) < 7)
			: 1'($urandom_range(1));
		roll = $urandom_range(99);
		if (eng_phase == i2cbb_pkg::PH_IDLE) begin
			if (roll < 86)
				w.command = 3'($urandom_range(i2cbb_pkg::CMD_READ, i2cbb_pkg::CMD_START));
			else if (roll < 94)
				w.command = i2cbb_pkg::CMD_NONE;
			else
				w.command = 3'($urandom_range(CMD_TOP, i2cbb_pkg::CMD_READ + 1));
		end else begin
			w.command = (roll < 90) ? i2cbb_pkg::CMD_NONE
				: 3'($urandom_range(CMD_TOP, i2cbb_pkg::CMD_NONE));
		end
		return w;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(i2cbb_pkg::in_word_t w, bit typed, i2cbb_pkg::out_word_t want);
		i2cbb_pkg::out_word_t got;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		if (eng_phase == i2cbb_pkg::PH_IDLE)
			op_count[w.command]++;
		if (eng_phase == i2cbb_pkg::PH_RS && !w.scl_in)
			stretch_ticks++;
		got = line_tick(w);
		expected_lines.push_back(typed ? want : got);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_slot(logic [15:0] v);
		in_valid <= 1'b0;
		while (expected_lines.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		slot_len = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Runs until n words that start or advance a sequence have gone in, then
	// lets the sequence in progress finish.
	task automatic run_random(int n);
		i2cbb_pkg::in_word_t w;
		int counted;
		counted = 0;
		while (counted < n) begin
			w = pick_word();
			if (eng_phase != i2cbb_pkg::PH_IDLE || (w.command >= i2cbb_pkg::CMD_START
					&& w.command <= i2cbb_pkg::CMD_READ))
				counted++;
			send_word(w, 1'b0, '0);
		end
		while (eng_phase != i2cbb_pkg::PH_IDLE)
			send_word(pick_word(), 1'b0, '0);
	endtask

	function automatic stim_row_t item_row(i2cbb_pkg::in_word_t w, bit typed,
			i2cbb_pkg::out_word_t want);
		stim_row_t r;
		r.is_cfg = 1'b0; r.cfg_val = '0; r.word = w; r.typed = typed; r.want = want;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [15:0] v);
		stim_row_t r;
		r.is_cfg = 1'b1; r.cfg_val = v; r.word = '0; r.typed = 1'b0; r.want = '0;
		return r;
	endfunction

	initial begin : main_seq
		stim_row_t           dir_rows[$];
		i2cbb_pkg::in_word_t tick_w;

		slot_len  = i2cbb_pkg::SLOT_TICKS_RESET;
		eng_phase = i2cbb_pkg::PH_IDLE;
		bit_idx   = '0;
		shifter   = '0;
		rx_byte   = '0;
		slot_cnt  = 0;
		ack_seen  = 1'b0;
		send_nack = 1'b0;
		scl_lv = 1'b1; scl_dr = 1'b0; sda_lv = 1'b1; sda_dr = 1'b0;
		foreach (op_count[i]) op_count[i] = 0;

		// Idle word straight after reset, and an unknown command that does nothing.
		dir_rows.push_back(item_row('{i2cbb_pkg::CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
			'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}));
		dir_rows.push_back(item_row('{CMD_TOP, 8'hFF, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}));
		// A zero slot length runs as one tick per slot.
		dir_rows.push_back(cfg_row(16'd0));
		dir_rows.push_back(item_row('{i2cbb_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
			'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00}));
		dir_rows.push_back(item_row('{i2cbb_pkg::CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b1},
			1'b0, '0));
		dir_rows.push_back(item_row('{i2cbb_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b1, 1'b1},
			1'b0, '0));
		// The stop given on the tick the start finishes is dropped.
		dir_rows.push_back(item_row('{i2cbb_pkg::CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
			'{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00}));
		dir_rows.push_back(item_row('{i2cbb_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0},
			1'b0, '0));
		for (int i = 0; i < 3; i++)
			dir_rows.push_back(item_row('{i2cbb_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0},
				1'b0, '0));
		// All-ones byte with SDA left high at the acknowledge: the error flag is set.
		dir_rows.push_back(item_row('{i2cbb_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1},
			1'b0, '0));
		for (int i = 0; i < 17; i++) begin
			tick_w = '{(i == 4) ? i2cbb_pkg::CMD_READ : i2cbb_pkg::CMD_NONE,
				8'h00, 1'b0, 1'b1, 1'b1};
			dir_rows.push_back(item_row(tick_w, 1'b0, '0));
		end
		dir_rows.push_back(item_row('{i2cbb_pkg::CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
			'{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00}));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 32;
		recv_idle_pct = 48;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_slot(dir_rows[i].cfg_val);
			else
				send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
		end
		run_random(350);
		write_slot(16'd3);
		run_random(350);

		send_idle_pct = 48;
		recv_idle_pct = 32;
		write_slot(16'd1);
		run_random(350);
		write_slot(16'd2);
		run_random(300);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_slot(16'd5);
		run_random(230);
		// One complete start with a long slot.
		write_slot(16'd40);
		send_word('{i2cbb_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0);
		run_random(0);

		in_valid <= 1'b0;
		while (expected_lines.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d words: %0d starts, %0d stops, %0d writes, %0d reads.",
			items_sent, op_count[i2cbb_pkg::CMD_START], op_count[i2cbb_pkg::CMD_STOP],
			op_count[i2cbb_pkg::CMD_WRITE], op_count[i2cbb_pkg::CMD_READ]);
		$display("Checked %0d results over slot lengths 0 to 40, %0d stretched SCL ticks.",
			results_checked, stretch_ticks);
		if (mismatches == 0 && expected_lines.size() == 0) begin
			$display("i2c_bitbang_master verification clean");
		end else begin
			$display("i2c_bitbang_master verification failed");
		end
		$finish;
	end

endmodule
